FILE: rtl/fraction_reduce_and_scalar_update_top_defines.svh
// Assertion macros shared by the fraction reduce and scalar update RTL.
// Each macro expects the including module to have aclk and aresetn in scope.
`ifndef FRACTION_REDUCE_AND_SCALAR_UPDATE_TOP_DEFINES_SVH
`define FRACTION_REDUCE_AND_SCALAR_UPDATE_TOP_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define FRSU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Implication: when cond holds, result must hold at the next edge.
`define FRSU_ASSERT_NEXT(label, cond, result, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (result)) else $error(msg);

`endif

FILE: rtl/frsu_pkg.sv
// Package for the fraction reduce and scalar update block.
// Holds command codes and the control and status types of the shared unit.
`default_nettype none

package frsu_pkg;

    // Command codes carried on s_tuser.
    localparam logic [2:0] CMD_LOAD = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_DIV  = 3'd4;

    // Operation of the shared shift/add unit.
    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    // Request from the sequencer to the shared unit.
    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

    // Status from the shared unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

endpackage

`default_nettype wire

FILE: rtl/frsu_alu.sv
// Shared iterative unit: shift-and-add multiply (low half) or signed
// truncating divide with remainder, one bit per cycle. Uses frsu_pkg.
`default_nettype none

module frsu_alu #(
    parameter int W = 32
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  frsu_pkg::alu_ctrl_t ctrl,
    input  wire [W-1:0]         opa,
    input  wire [W-1:0]         opb,
    output frsu_pkg::alu_stat_t stat,
    output logic [W-1:0]        res_q,
    output logic [W-1:0]        res_r
);

    localparam int CW = $clog2(W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    frsu_pkg::alu_op_t   op_reg, op_next;
    logic [W-1:0]        acc_reg, acc_next;
    logic [W-1:0]        x_reg, x_next;
    logic [W-1:0]        y_reg, y_next;
    logic                sq_reg, sq_next;
    logic                sr_reg, sr_next;

    logic [W:0]          rem_sh;
    logic [W:0]          diff;
    logic [W-1:0]        mag_a;
    logic [W-1:0]        mag_b;

    // Magnitudes of the operands for the divider.
    assign mag_a = opa[W-1] ? (W'(0) - opa) : opa;
    assign mag_b = opb[W-1] ? (W'(0) - opb) : opb;

    // Restoring divide step: shift in the next dividend bit, try a subtract.
    assign rem_sh = {acc_reg, x_reg[W-1]};
    assign diff   = rem_sh - {1'b0, y_reg};

    // Load on start, otherwise step while busy.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        sq_next   = sq_reg;
        sr_next   = sr_reg;
        if (ctrl.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = ctrl.op;
            acc_next  = '0;
            if (ctrl.op == frsu_pkg::ALU_DIV) begin
                x_next  = mag_a;
                y_next  = mag_b;
                sq_next = opa[W-1] ^ opb[W-1];
                sr_next = opa[W-1];
            end else begin
                x_next  = opa;
                y_next  = opb;
                sq_next = 1'b0;
                sr_next = 1'b0;
            end
        end else if (busy_reg) begin
            cnt_next = cnt_reg + CW'(1);
            if (op_reg == frsu_pkg::ALU_DIV) begin
                if (!diff[W]) begin
                    acc_next = diff[W-1:0];
                end else begin
                    acc_next = rem_sh[W-1:0];
                end
                x_next = {x_reg[W-2:0], ~diff[W]};
            end else begin
                if (y_reg[0]) begin
                    acc_next = acc_reg + x_reg;
                end
                x_next = {x_reg[W-2:0], 1'b0};
                y_next = {1'b0, y_reg[W-1:1]};
            end
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= frsu_pkg::ALU_MUL;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        sq_reg  <= sq_next;
        sr_reg  <= sr_next;
    end

    // Results: product, or signed quotient and remainder.
    always_comb begin
        if (op_reg == frsu_pkg::ALU_DIV) begin
            res_q = sq_reg ? (W'(0) - x_reg) : x_reg;
            res_r = sr_reg ? (W'(0) - acc_reg) : acc_reg;
        end else begin
            res_q = acc_reg;
            res_r = '0;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`include "fraction_reduce_and_scalar_update_top_defines.svh"

    `FRSU_ASSERT_NEXT(a_start_busy, ctrl.start && !busy_reg, busy_reg, "start did not set busy")
    `FRSU_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "done held longer than one cycle")
    `FRSU_ASSERT(a_rem_small, (done_reg && op_reg == frsu_pkg::ALU_DIV) |-> (acc_reg < y_reg), "remainder not below divisor")

endmodule

`default_nettype wire

FILE: rtl/fraction_reduce_and_scalar_update_top.sv
// Top level of the fraction reduce and scalar update block: sequencer,
// held fraction and output register. Uses frsu_pkg and frsu_alu.
//
//  channel | dir | tdata (low bit up)                    | tuser
//  s_      | in  | operand_value[31:0], load_denominator | cmd[2:0]
//  m_      | out | numerator_out[31:0], denominator_out  | -
//
// Every multiply and divide runs on one shared unit. A scalar command takes one
// multiply; a load takes one divide per Euclid remainder step and then two more
// to reduce the numerator and the denominator by the GCD, unless both are zero.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register, and a new transaction can be taken meanwhile.
// Reset (aresetn low, synchronous) sets the fraction to 0/1.
`default_nettype none

module fraction_reduce_and_scalar_update_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // operand_value[31:0], load_denominator[63:32]
    input  wire  [2:0]  s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata    // numerator_out[31:0], denominator_out[63:32]
);

    localparam int W = VALUE_WIDTH;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_GCD      = 8'b0000_0010,
        ST_GCD_WAIT = 8'b0000_0100,
        ST_NUM_WAIT = 8'b0000_1000,
        ST_DEN_WAIT = 8'b0001_0000,
        ST_SCALAR   = 8'b0010_0000,
        ST_MUL_WAIT = 8'b0100_0000,
        ST_WRITE    = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [W-1:0]        x_reg, x_next;
    logic [W-1:0]        num_reg, num_next;
    logic [W-1:0]        den_reg, den_next;
    logic [W-1:0]        ga_reg, ga_next;
    logic [W-1:0]        gb_reg, gb_next;
    logic                m_valid_reg, m_valid_next;
    logic [63:0]         m_data_reg, m_data_next;

    frsu_pkg::alu_ctrl_t alu_ctrl;
    frsu_pkg::alu_stat_t alu_stat;
    logic [W-1:0]        alu_a;
    logic [W-1:0]        alu_b;
    logic [W-1:0]        alu_q;
    logic [W-1:0]        alu_r;

    logic                s_accept;
    logic [W-1:0]        in_a;
    logic [W-1:0]        in_b;

    logic                alu_waiting;
    logic                gcd_dividing;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Inputs are sign-extended or wrapped to the internal width.
    assign in_a = W'(signed'(s_tdata[31:0]));
    assign in_b = W'(signed'(s_tdata[63:32]));

    frsu_alu #(
        .W (W)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (alu_ctrl),
        .opa     (alu_a),
        .opb     (alu_b),
        .stat    (alu_stat),
        .res_q   (alu_q),
        .res_r   (alu_r)
    );

    // Sequencer and held fraction.
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        x_next       = x_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        ga_next      = ga_reg;
        gb_next      = gb_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        alu_ctrl     = '{start: 1'b0, op: frsu_pkg::ALU_DIV};
        alu_a        = ga_reg;
        alu_b        = gb_reg;

        // The output register empties when the consumer takes the transaction.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_next = s_tuser;
                    x_next   = in_a;
                    case (s_tuser)
                        frsu_pkg::CMD_LOAD: begin
                            num_next   = in_a;
                            den_next   = in_b;
                            ga_next    = in_a;
                            gb_next    = in_b;
                            state_next = ST_GCD;
                        end
                        frsu_pkg::CMD_ADD, frsu_pkg::CMD_SUB,
                        frsu_pkg::CMD_MUL, frsu_pkg::CMD_DIV: begin
                            state_next = ST_SCALAR;
                        end
                        default: begin
                            state_next = ST_WRITE;
                        end
                    endcase
                end
            end
            // One Euclid step per pass: (a, b) becomes (b, a rem b); once b is zero, reduce by a.
            ST_GCD: begin
                if (gb_reg != '0) begin
                    alu_ctrl   = '{start: 1'b1, op: frsu_pkg::ALU_DIV};
                    state_next = ST_GCD_WAIT;
                end else if (ga_reg != '0) begin
                    alu_ctrl   = '{start: 1'b1, op: frsu_pkg::ALU_DIV};
                    alu_a      = num_reg;
                    alu_b      = ga_reg;
                    state_next = ST_NUM_WAIT;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_GCD_WAIT: begin
                if (alu_stat.done) begin
                    ga_next    = gb_reg;
                    gb_next    = alu_r;
                    state_next = ST_GCD;
                end
            end
            // Numerator reduced; start the denominator right away.
            ST_NUM_WAIT: begin
                if (alu_stat.done) begin
                    num_next   = alu_q;
                    alu_ctrl   = '{start: 1'b1, op: frsu_pkg::ALU_DIV};
                    alu_a      = den_reg;
                    alu_b      = ga_reg;
                    state_next = ST_DEN_WAIT;
                end
            end
            ST_DEN_WAIT: begin
                if (alu_stat.done) begin
                    den_next   = alu_q;
                    state_next = ST_WRITE;
                end
            end
            ST_SCALAR: begin
                alu_ctrl   = '{start: 1'b1, op: frsu_pkg::ALU_MUL};
                alu_a      = (cmd_reg == frsu_pkg::CMD_MUL) ? num_reg : den_reg;
                alu_b      = x_reg;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (alu_stat.done) begin
                    case (cmd_reg)
                        frsu_pkg::CMD_ADD: num_next = num_reg + alu_q;
                        frsu_pkg::CMD_SUB: num_next = num_reg - alu_q;
                        frsu_pkg::CMD_MUL: num_next = alu_q;
                        default:           den_next = alu_q;
                    endcase
                    state_next = ST_WRITE;
                end
            end
            // Present the fraction once the output register is free.
            ST_WRITE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {32'(signed'(den_reg)), 32'(signed'(num_reg))};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            num_reg     <= '0;
            den_reg     <= W'(1);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            num_reg     <= num_next;
            den_reg     <= den_next;
        end
        cmd_reg    <= cmd_next;
        x_reg      <= x_next;
        ga_reg     <= ga_next;
        gb_reg     <= gb_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // States in which the sequencer waits on the shared unit.
    assign alu_waiting  = (state_reg inside {ST_GCD_WAIT, ST_NUM_WAIT, ST_DEN_WAIT, ST_MUL_WAIT});
    assign gcd_dividing = (state_reg inside {ST_NUM_WAIT, ST_DEN_WAIT});

`include "fraction_reduce_and_scalar_update_top_defines.svh"

    `FRSU_ASSERT(a_start_free, alu_ctrl.start |-> !alu_stat.busy, "shared unit started while busy")
    `FRSU_ASSERT(a_done_waiting, alu_stat.done |-> alu_waiting, "result not awaited")
    `FRSU_ASSERT(a_gcd_nonzero, gcd_dividing |-> (ga_reg != '0), "division by a zero GCD")

endmodule

`default_nettype wire
